/* src/swrs_pkg.sv */
// swrs_pkg: shared types, codes and constants of the stop-and-wait result sender
// no dependencies; imported by every module, not by the channel interfaces

package swrs_pkg;

    // packets per run; index WHEEL_COUNT is the end marker
    localparam int unsigned WHEEL_COUNT = 4;
    localparam logic [2:0]  MARKER_INDEX = 3'(WHEEL_COUNT);

    // event opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_OK     = 3'd1;
    localparam logic [2:0] OP_NG     = 3'd2;
    localparam logic [2:0] OP_ACK    = 3'd3;
    localparam logic [2:0] OP_ABORT  = 3'd4;

    // outcome codes
    localparam logic [1:0] OUTCOME_NONE = 2'd0;
    localparam logic [1:0] OUTCOME_DONE = 2'd1;
    localparam logic [1:0] OUTCOME_FAIL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_LOCAL_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_GUARD         = 2'd2;
    localparam logic [1:0] REG_MAX_RETRIES   = 2'd3;

    // configuration reset values
    localparam logic [15:0] LOCAL_TIMEOUT_RST = 16'd500;
    localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd1000;
    localparam logic [15:0] GUARD_RST         = 16'd50;
    localparam logic [7:0]  MAX_RETRIES_RST   = 8'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOCAL  = 2'd1,
        PH_REMOTE = 2'd2,
        PH_GUARD  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [15:0] local_timeout_ticks;
        logic [15:0] ack_timeout_ticks;
        logic [15:0] guard_ticks;
        logic [7:0]  max_retries;
    } cfg_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] ack_index;
        logic       results_ready;
        logic       abort_clears;
    } evt_t;

    typedef struct packed {
        logic       send_now;
        logic [2:0] send_index;
        logic       send_marker;
        logic       clear_ready;
        logic [1:0] outcome;
        logic [1:0] phase_now;
        logic [7:0] attempt_now;
    } res_t;

endpackage

/* src/swrs_channels.sv */
// swrs_evt_if and swrs_res_if: valid/ready channels for event and result beats
// depends on nothing; field widths follow the package types

interface swrs_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] ack_index;
    logic       results_ready;
    logic       abort_clears;

    modport source (output valid, opcode, ack_index, results_ready, abort_clears,
                    input ready);
    modport sink (input valid, opcode, ack_index, results_ready, abort_clears,
                  output ready);
endinterface

interface swrs_res_if;
    logic       valid;
    logic       ready;
    logic       send_now;
    logic [2:0] send_index;
    logic       send_marker;
    logic       clear_ready;
    logic [1:0] outcome;
    logic [1:0] phase_now;
    logic [7:0] attempt_now;

    modport source (output valid, send_now, send_index, send_marker, clear_ready,
                    outcome, phase_now, attempt_now, input ready);
    modport sink (input valid, send_now, send_index, send_marker, clear_ready,
                  outcome, phase_now, attempt_now, output ready);
endinterface

/* src/swrs_cfg.sv */
// swrs_cfg: configuration registers written through the plain write port
// depends on swrs_pkg

module swrs_cfg
    import swrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCAL_TIMEOUT: cfg_next.local_timeout_ticks = cfg_wdata;
                REG_ACK_TIMEOUT:   cfg_next.ack_timeout_ticks   = cfg_wdata;
                REG_GUARD:         cfg_next.guard_ticks         = cfg_wdata;
                REG_MAX_RETRIES:   cfg_next.max_retries         = cfg_wdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_timeout_ticks <= LOCAL_TIMEOUT_RST;
            cfg_reg.ack_timeout_ticks   <= ACK_TIMEOUT_RST;
            cfg_reg.guard_ticks         <= GUARD_RST;
            cfg_reg.max_retries         <= MAX_RETRIES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/swrs_core.sv */
// swrs_core: event input register, sender state and next-state logic
// depends on swrs_pkg and swrs_evt_if; hands one result per event downstream

module swrs_core
    import swrs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    swrs_evt_if.sink        evt,
    output logic            res_valid,
    output res_t            res,
    input  logic            res_ready
);

    logic        evt_valid_reg;
    evt_t        evt_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  index_reg;
    logic [2:0]  index_next;
    logic [7:0]  attempts_reg;
    logic [7:0]  attempts_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;

    logic        step;
    logic        over_limit;
    logic [15:0] elapsed_inc;
    logic        ack_match;
    res_t        res_comb;

    assign step       = evt_valid_reg && res_ready;
    assign evt.ready  = !evt_valid_reg || res_ready;
    assign over_limit = attempts_reg > cfg.max_retries;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign ack_match  = (evt_reg.ack_index == {5'd0, index_reg}) && (index_reg <= MARKER_INDEX);

    // next state and result for the event held in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        attempts_next = attempts_reg;
        elapsed_next  = elapsed_reg;
        res_comb      = '0;

        case (evt_reg.opcode)
            OP_TICK:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    // run start sends packet 0 at once
                    if (evt_reg.results_ready)
                    begin
                        index_next           = 3'd0;
                        attempts_next        = 8'd1;
                        res_comb.send_now    = 1'b1;
                        res_comb.send_index  = 3'd0;
                        res_comb.send_marker = (MARKER_INDEX == 3'd0);
                        phase_next           = PH_LOCAL;
                        elapsed_next         = 16'd0;
                    end
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                    if ((phase_reg == PH_LOCAL && elapsed_inc >= cfg.local_timeout_ticks) ||
                        (phase_reg == PH_REMOTE && elapsed_inc >= cfg.ack_timeout_ticks))
                    begin
                        // timeout: retry after guard unless out of attempts
                        if (over_limit)
                        begin
                            res_comb.clear_ready = 1'b1;
                            res_comb.outcome     = OUTCOME_FAIL;
                            phase_next           = PH_IDLE;
                            index_next           = 3'd0;
                            attempts_next        = 8'd0;
                            elapsed_next         = 16'd0;
                        end
                        else
                        begin
                            phase_next   = PH_GUARD;
                            elapsed_next = 16'd0;
                        end
                    end
                    else if (phase_reg == PH_GUARD && elapsed_inc >= cfg.guard_ticks)
                    begin
                        // guard over: (re)send current packet, or fail the run if out of attempts
                        if (over_limit)
                        begin
                            res_comb.clear_ready = 1'b1;
                            res_comb.outcome     = OUTCOME_FAIL;
                            phase_next           = PH_IDLE;
                            index_next           = 3'd0;
                            attempts_next        = 8'd0;
                            elapsed_next         = 16'd0;
                        end
                        else if (index_reg <= MARKER_INDEX)
                        begin
                            if (attempts_reg != 8'hFF)
                            begin
                                attempts_next = attempts_reg + 8'd1;
                            end
                            res_comb.send_now    = 1'b1;
                            res_comb.send_index  = index_reg;
                            res_comb.send_marker = (index_reg == MARKER_INDEX);
                            phase_next           = PH_LOCAL;
                            elapsed_next         = 16'd0;
                        end
                    end
                end
            end
            OP_OK:
            begin
                if (phase_reg == PH_LOCAL)
                begin
                    phase_next   = PH_REMOTE;
                    elapsed_next = 16'd0;
                end
            end
            OP_NG:
            begin
                if (phase_reg == PH_LOCAL)
                begin
                    if (over_limit)
                    begin
                        res_comb.clear_ready = 1'b1;
                        res_comb.outcome     = OUTCOME_FAIL;
                        phase_next           = PH_IDLE;
                        index_next           = 3'd0;
                        attempts_next        = 8'd0;
                        elapsed_next         = 16'd0;
                    end
                    else
                    begin
                        phase_next   = PH_GUARD;
                        elapsed_next = 16'd0;
                    end
                end
            end
            OP_ACK:
            begin
                if (phase_reg == PH_REMOTE && ack_match)
                begin
                    if (index_reg == MARKER_INDEX)
                    begin
                        // end marker acknowledged: run complete
                        res_comb.clear_ready = 1'b1;
                        res_comb.outcome     = OUTCOME_DONE;
                        phase_next           = PH_IDLE;
                        index_next           = 3'd0;
                        attempts_next        = 8'd0;
                        elapsed_next         = 16'd0;
                    end
                    else
                    begin
                        index_next    = index_reg + 3'd1;
                        attempts_next = 8'd0;
                        phase_next    = PH_GUARD;
                        elapsed_next  = 16'd0;
                    end
                end
            end
            OP_ABORT:
            begin
                res_comb.clear_ready = (phase_reg != PH_IDLE) && evt_reg.abort_clears;
                phase_next           = PH_IDLE;
                index_next           = 3'd0;
                attempts_next        = 8'd0;
                elapsed_next         = 16'd0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        res_comb.phase_now   = phase_next;
        res_comb.attempt_now = attempts_next;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            evt_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            evt_reg.opcode        <= evt.opcode;
            evt_reg.ack_index     <= evt.ack_index;
            evt_reg.results_ready <= evt.results_ready;
            evt_reg.abort_clears  <= evt.abort_clears;
        end
    end

    // sender state, advanced once per event handed downstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            index_reg    <= 3'd0;
            attempts_reg <= 8'd0;
            elapsed_reg  <= 16'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            attempts_reg <= attempts_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    assign res_valid = evt_valid_reg;
    assign res       = res_comb;

endmodule

/* src/swrs_out.sv */
// swrs_out: result register that drives the result channel
// depends on swrs_pkg and swrs_res_if

module swrs_out
    import swrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  res_t        res,
    output logic        res_ready,
    swrs_res_if.source  rsp
);

    logic out_valid_reg;
    res_t out_reg;

    assign res_ready = !out_valid_reg || rsp.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.send_now    = out_reg.send_now;
    assign rsp.send_index  = out_reg.send_index;
    assign rsp.send_marker = out_reg.send_marker;
    assign rsp.clear_ready = out_reg.clear_ready;
    assign rsp.outcome     = out_reg.outcome;
    assign rsp.phase_now   = out_reg.phase_now;
    assign rsp.attempt_now = out_reg.attempt_now;

endmodule

/* src/stop_and_wait_result_sender.sv */
// stop_and_wait_result_sender: top level of the stop-and-wait result sender
// depends on swrs_pkg, swrs_channels, swrs_cfg, swrs_core and swrs_out

// Stop-and-wait sender for a run of WHEEL_COUNT result packets plus an end marker.
// Each event beat (tick, local OK, local NG, remote ack, abort) gives exactly one
// result beat. An event passes through an input register and the next-state logic
// into a result register, which offers the result beat on the result channel.
// One event is taken every cycle while the result side keeps up; a stall on
// the result side backs up through both registers. Configuration writes take
// effect on the next cycle and belong in idle time only.

module stop_and_wait_result_sender
    import swrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    swrs_evt_if.sink    evt,
    swrs_res_if.source  rsp
);

    cfg_t cfg;
    logic res_valid;
    logic res_ready;
    res_t res;

    // configuration registers
    swrs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // event register and sender state
    swrs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt       (evt),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // result register
    swrs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .rsp       (rsp)
    );

endmodule

/* sim/stop_and_wait_result_sender_tb.sv */
// stop_and_wait_result_sender_tb: self-checking bench for the stop-and-wait result sender
// depends on swrs_pkg, swrs_channels and the stop_and_wait_result_sender rtl
// a tracker class mirrors the sender state machine and checks every result beat in order

`timescale 1ns / 100ps

module stop_and_wait_result_sender_tb;
    import swrs_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          ITEMS_PER_SETTING = 250;
    localparam int          DRAIN_CYCLES = 6;
    localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

    // mirror of the sender: phase, packet number, attempt count and tick count
    class arq_tracker;
        cfg_t        cfg;
        phase_t      phase;
        logic [2:0]  pkt;
        logic [7:0]  attempts;
        logic [15:0] elapsed;
        res_t        step_out;
        res_t        pending_results[$];
        int          errors;

        function new();
            cfg.local_timeout_ticks = LOCAL_TIMEOUT_RST;
            cfg.ack_timeout_ticks   = ACK_TIMEOUT_RST;
            cfg.guard_ticks         = GUARD_RST;
            cfg.max_retries         = MAX_RETRIES_RST;
            errors = 0;
            clear_run();
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_LOCAL_TIMEOUT: cfg.local_timeout_ticks = value;
                REG_ACK_TIMEOUT:   cfg.ack_timeout_ticks = value;
                REG_GUARD:         cfg.guard_ticks = value;
                REG_MAX_RETRIES:   cfg.max_retries = value[7:0];
                default: ;
            endcase
        endfunction

        function void clear_run();
            phase    = PH_IDLE;
            pkt      = '0;
            attempts = '0;
            elapsed  = '0;
        endfunction

        function void fail_run();
            step_out.clear_ready = 1'b1;
            step_out.outcome     = OUTCOME_FAIL;
            clear_run();
        endfunction

        // timeout or local NG: fail once the retries are used up, else wait out the guard
        function void retry_or_fail();
            if (attempts > cfg.max_retries)
                fail_run();
            else
            begin
                phase   = PH_GUARD;
                elapsed = '0;
            end
        endfunction

        function void send_packet();
            if (attempts > cfg.max_retries)
                fail_run();
            else
            begin
                if (attempts != 8'hFF)
                    attempts = attempts + 8'd1;
                step_out.send_now    = 1'b1;
                step_out.send_index  = pkt;
                step_out.send_marker = (pkt == MARKER_INDEX);
                phase   = PH_LOCAL;
                elapsed = '0;
            end
        endfunction

        function void tick(logic ready_in);
            if (phase == PH_IDLE)
            begin
                if (ready_in)
                begin
                    pkt      = '0;
                    attempts = '0;
                    send_packet();
                end
            end
            else
            begin
                if (elapsed != 16'hFFFF)
                    elapsed = elapsed + 16'd1;
                case (phase)
                    PH_LOCAL:
                        if (elapsed >= cfg.local_timeout_ticks)
                            retry_or_fail();
                    PH_REMOTE:
                        if (elapsed >= cfg.ack_timeout_ticks)
                            retry_or_fail();
                    default:
                        if (elapsed >= cfg.guard_ticks)
                            send_packet();
                endcase
            end
        endfunction

        // one event beat accepted: advance the mirror and queue its result
        function void take_event(evt_t e);
            step_out = '0;
            case (e.opcode)
                OP_TICK: tick(e.results_ready);
                OP_OK:
                    if (phase == PH_LOCAL)
                    begin
                        phase   = PH_REMOTE;
                        elapsed = '0;
                    end
                OP_NG:
                    if (phase == PH_LOCAL)
                        retry_or_fail();
                OP_ACK:
                    if (phase == PH_REMOTE && e.ack_index == {5'd0, pkt} && pkt <= MARKER_INDEX)
                    begin
                        if (pkt == MARKER_INDEX)
                        begin
                            step_out.clear_ready = 1'b1;
                            step_out.outcome     = OUTCOME_DONE;
                            clear_run();
                        end
                        else
                        begin
                            pkt      = pkt + 3'd1;
                            attempts = '0;
                            phase    = PH_GUARD;
                            elapsed  = '0;
                        end
                    end
                OP_ABORT:
                begin
                    if (phase != PH_IDLE && e.abort_clears)
                        step_out.clear_ready = 1'b1;
                    clear_run();
                end
                default: ;
            endcase
            step_out.phase_now   = phase;
            step_out.attempt_now = attempts;
            pending_results.push_back(step_out);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("send_now", 8'(want.send_now), 8'(got.send_now));
            check_field("send_index", 8'(want.send_index), 8'(got.send_index));
            check_field("send_marker", 8'(want.send_marker), 8'(got.send_marker));
            check_field("clear_ready", 8'(want.clear_ready), 8'(got.clear_ready));
            check_field("outcome", 8'(want.outcome), 8'(got.outcome));
            check_field("phase_now", 8'(want.phase_now), 8'(got.phase_now));
            check_field("attempt_now", want.attempt_now, got.attempt_now);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          gap_pct;
    int          stall_pct;
    int          cycles;

    swrs_evt_if evt ();
    swrs_res_if rsp ();

    arq_tracker tracker = new();

    stop_and_wait_result_sender dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .evt       (evt),
        .rsp       (rsp)
    );

    // clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("stop_and_wait_result_sender: mismatch");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    // result beat check
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            tracker.check_result(res_t'({rsp.send_now, rsp.send_index, rsp.send_marker,
                                         rsp.clear_ready, rsp.outcome, rsp.phase_now,
                                         rsp.attempt_now}));
    end

    // one event beat, with random idle cycles ahead of it; called and returns at a falling edge
    task automatic send_event(evt_t e);
        while ($urandom_range(99) < gap_pct)
        begin
            evt.valid <= 1'b0;
            @(negedge clk);
        end
        evt.valid         <= 1'b1;
        evt.opcode        <= e.opcode;
        evt.ack_index     <= e.ack_index;
        evt.results_ready <= e.results_ready;
        evt.abort_clears  <= e.abort_clears;
        do
            @(posedge clk);
        while (!evt.ready);
        tracker.take_event(e);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        tracker.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic set_config(logic [15:0] lt, logic [15:0] at, logic [15:0] gt,
                              logic [15:0] mr);
        write_reg(REG_LOCAL_TIMEOUT, lt);
        write_reg(REG_ACK_TIMEOUT, at);
        write_reg(REG_GUARD, gt);
        write_reg(REG_MAX_RETRIES, mr);
        cfg_we <= 1'b0;
    endtask

    // stop sending and wait for every pending result, plus the pipeline depth
    task automatic settle();
        evt.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly well-formed traffic for the current phase, with some noise and aborts
    function automatic evt_t pick_event();
        evt_t e;
        int   roll;
        roll = $urandom_range(99);
        e.opcode        = OP_TICK;
        e.ack_index     = 8'($urandom_range(255));
        e.results_ready = 1'($urandom_range(1));
        e.abort_clears  = 1'($urandom_range(1));
        if (roll < 2)
            e.opcode = OP_ABORT;
        else if (roll < 4)
            e.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if (roll < 8)
            e.opcode = 3'($urandom_range(OP_OK, OP_ACK));
        else
        begin
            case (tracker.phase)
                PH_IDLE:
                    e.results_ready = (roll < 80);
                PH_LOCAL:
                    if (roll >= 75)
                        e.opcode = OP_NG;
                    else if (roll >= 40)
                        e.opcode = OP_OK;
                PH_REMOTE:
                    if (roll >= 45)
                    begin
                        e.opcode = OP_ACK;
                        if (roll < 90)
                            e.ack_index = {5'd0, tracker.pkt};
                    end
                default: ;
            endcase
        end
        return e;
    endfunction

    initial
    begin
        int seg;
        int k;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        evt.valid         = 1'b0;
        evt.opcode        = OP_TICK;
        evt.ack_index     = '0;
        evt.results_ready = 1'b0;
        evt.abort_clears  = 1'b0;
        cycles            = 0;
        gap_pct           = 23;
        stall_pct         = 52;

        // reset
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: short timers, no guard, one retry
        set_config(16'd2, 16'd2, 16'd0, 16'd1);
        @(negedge clk);

        // events that idle ignores, fields at their extremes
        send_event('{OP_UNUSED_HI, 8'hFF, 1'b1, 1'b1});
        send_event('{OP_OK, 8'h00, 1'b0, 1'b0});
        send_event('{OP_NG, 8'h00, 1'b0, 1'b0});
        send_event('{OP_ACK, 8'h00, 1'b0, 1'b0});
        send_event('{OP_ABORT, 8'h00, 1'b0, 1'b1});
        send_event('{OP_TICK, 8'h00, 1'b0, 1'b0});

        // complete run through the end marker, one stray ack on the way
        send_event('{OP_TICK, 8'h00, 1'b1, 1'b0});
        for (int i = 0; i <= WHEEL_COUNT; i++)
        begin
            send_event('{OP_OK, 8'h00, 1'b0, 1'b0});
            if (i == 0)
                send_event('{OP_ACK, 8'hFF, 1'b0, 1'b0});
            send_event('{OP_ACK, 8'(i), 1'b0, 1'b0});
            if (i < WHEEL_COUNT)
                send_event('{OP_TICK, 8'h00, 1'b0, 1'b0});
        end

        // local timeout, resend, then NG past the retry limit fails the run
        send_event('{OP_TICK, 8'h00, 1'b1, 1'b0});
        send_event('{OP_TICK, 8'h00, 1'b0, 1'b0});
        send_event('{OP_TICK, 8'h00, 1'b0, 1'b0});
        send_event('{OP_TICK, 8'h00, 1'b0, 1'b0});
        send_event('{OP_NG, 8'h00, 1'b0, 1'b0});

        // abort of an active run with clear requested
        send_event('{OP_TICK, 8'h00, 1'b1, 1'b0});
        send_event('{OP_ABORT, 8'h00, 1'b0, 1'b1});

        // random part: three idling modes, two register settings each
        for (seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    gap_pct   = 23;
                    stall_pct = 52;
                end
                1:
                begin
                    gap_pct   = 52;
                    stall_pct = 23;
                end
                default:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            for (k = 0; k < 2; k++)
            begin
                settle();
                case (seg * 2 + k)
                    0: set_config(16'd3, 16'd4, 16'd1, 16'd2);
                    1: set_config(16'd1, 16'd1, 16'd0, 16'd0);
                    2: set_config(16'd5, 16'd8, 16'd2, 16'd254);
                    3: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd254);
                    4: set_config(16'd2, 16'd3, 16'd3, 16'd1);
                    default: set_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                                        16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
                endcase
                @(negedge clk);
                repeat (ITEMS_PER_SETTING) send_event(pick_event());
            end
        end

        // drain and report
        settle();
        if (tracker.errors == 0)
            $display("stop_and_wait_result_sender: match");
        else
            $display("stop_and_wait_result_sender: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
src/swrs_pkg.sv
src/swrs_channels.sv
src/swrs_cfg.sv
src/swrs_core.sv
src/swrs_out.sv
src/stop_and_wait_result_sender.sv
sim/stop_and_wait_result_sender_tb.sv
